// ===== src/kcg_pkg.sv =====
// Package for the k-combination generator.
// Holds beat payload types, operation codes, register indexes, state and cell control types.
// No dependencies.
package kcg_pkg;

   localparam int KCG_MAX_LIST   = 64;
   localparam int KCG_MAX_CHOOSE = 16;

   localparam logic REG_LIST_LENGTH = 1'b0;
   localparam logic REG_SUBSET_SIZE = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_NEXT  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLAN,
      ST_EMIT,
      ST_EXH
   } state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [5:0]         load_index;
      logic signed [31:0] load_value;
   } req_type;

   typedef struct packed {
      logic [3:0]         position;
      logic [5:0]         item_index;
      logic signed [31:0] item_value;
      logic               last;
      logic               exhausted;
   } rsp_type;

   typedef struct packed {
      logic init;
      logic plan;
      logic shift;
   } cell_ctl_type;

endpackage

// ===== src/k_combination_generator.sv =====
// Top level of the k-combination generator: APB register port, element store, row of index
// cells, control sequencer and a two-beat result buffer.
// Depends on kcg_pkg, kcg_ram and kcg_cell.
//
// A start emits subset_size result beats, one result beat per cycle while the result port
// takes them; a next first passes through a planning step in the cell row. Each beat passes
// the registered store read and then the result buffer on its way to the result port, and a
// stalled result port holds the issue. The rate is set by the row of index cells, which
// rotates by one slot per emitted beat, and by the single read port of the element store. A
// next with no subset left, or a start whose subset size is zero, above list_length or above
// MAX_CHOOSE, returns one exhausted beat. Exhaustion holds until the next valid start.
// Reading an element never loaded gives an undefined value.
module k_combination_generator
   import kcg_pkg::*;
#(
   parameter int MAX_LIST   = KCG_MAX_LIST,
   parameter int MAX_CHOOSE = KCG_MAX_CHOOSE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W = $clog2(MAX_LIST);
   localparam int NW    = $clog2(MAX_LIST + 1);
   localparam int KW    = $clog2(MAX_CHOOSE + 1);
   localparam int CW    = $clog2(MAX_LIST + MAX_CHOOSE + 1);
   localparam int PW    = KW > 4 ? KW : 4;
   localparam int XW    = IDX_W > 6 ? IDX_W : 6;

   logic [6:0]       list_length_ff;
   logic [4:0]       subset_size_ff;
   logic             csr_wr;

   state_type        state_ff, state_in;
   logic             done_ff;
   logic [KW-1:0]    run_k_ff;
   logic [NW-1:0]    base_ff;
   logic [KW-1:0]    pos_ff;
   logic             after_ff;
   logic [IDX_W-1:0] prev_ff;

   logic             req_acc;
   op_type           op;
   logic [NW-1:0]    n_clamp;
   logic             start_bad;
   logic             found;
   logic             issue_ok;
   logic             issue_exh;
   logic             last_slot;
   logic [IDX_W-1:0] head_new;
   cell_ctl_type     ctl;

   logic [IDX_W-1:0] idx_w  [MAX_CHOOSE];
   logic             mark_w [MAX_CHOOSE];
   logic             can_w  [MAX_CHOOSE];
   logic [MAX_CHOOSE-1:0] mark_vec;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [XW-1:0]    load_index_wide;
   logic [31:0]      ram_rdata;

   logic             infl_valid_ff;
   rsp_type          infl_meta_ff, issue_meta;
   logic [PW-1:0]    pos_wide;
   logic [XW-1:0]    head_wide;

   rsp_type          ent_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff;
   logic             pop;
   rsp_type          push_beat;

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         list_length_ff <= '0;
         subset_size_ff <= '0;
      end else if (csr_wr) begin
         if (paddr[2] == REG_LIST_LENGTH) begin
            list_length_ff <= pwdata[6:0];
         end else begin
            subset_size_ff <= pwdata[4:0];
         end
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LIST_LENGTH: prdata = 32'(list_length_ff);
         REG_SUBSET_SIZE: prdata = 32'(subset_size_ff);
         default:         prdata = '0;
      endcase
   end

   // Start checks
   always_comb begin
      op        = op_type'(req_data.operation);
      req_acc   = req_valid && req_ready;
      n_clamp   = (int'(list_length_ff) > MAX_LIST) ? NW'(MAX_LIST) : NW'(list_length_ff);
      start_bad = (subset_size_ff == '0) || (int'(subset_size_ff) > int'(n_clamp))
                  || (int'(subset_size_ff) > MAX_CHOOSE);
   end

   // Cell row
   always_comb begin
      ctl.init  = req_acc && (op == OP_START) && !start_bad;
      ctl.plan  = state_ff == ST_PLAN;
      ctl.shift = (state_ff == ST_EMIT) && issue_ok;
      found     = can_w[0];
      priority if (mark_w[0]) begin
         head_new = idx_w[0] + IDX_W'(1);
      end else if (after_ff) begin
         head_new = prev_ff + IDX_W'(1);
      end else begin
         head_new = idx_w[0];
      end
   end

   for (genvar s = 0; s < MAX_CHOOSE; s++) begin : g_cell
      logic [IDX_W-1:0] nb_idx;
      logic             nb_mark;
      logic             nb_can;

      if (s < MAX_CHOOSE - 1) begin : g_inner
         assign nb_idx  = idx_w[s+1];
         assign nb_mark = mark_w[s+1];
         assign nb_can  = can_w[s+1];
      end else begin : g_end
         assign nb_idx  = head_new;
         assign nb_mark = 1'b0;
         assign nb_can  = 1'b0;
      end

      kcg_cell #(
         .IDX_W (IDX_W),
         .KW    (KW),
         .NW    (NW),
         .CW    (CW),
         .SLOT  (s)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .run_k     (run_k_ff),
         .base      (base_ff),
         .next_idx  (nb_idx),
         .next_mark (nb_mark),
         .next_can  (nb_can),
         .fb_idx    (head_new),
         .idx       (idx_w[s]),
         .mark      (mark_w[s]),
         .can       (can_w[s])
      );

      assign mark_vec[s] = mark_w[s];
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (op == OP_START)) begin
               state_in = start_bad ? ST_EXH : ST_EMIT;
            end else if (req_acc && (op == OP_NEXT)) begin
               state_in = done_ff ? ST_EXH : ST_PLAN;
            end
         end
         ST_PLAN: state_in = found ? ST_EMIT : ST_EXH;
         ST_EMIT: begin
            if (issue_ok && last_slot) begin
               state_in = ST_IDLE;
            end
         end
         ST_EXH: begin
            if (issue_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = state_ff == ST_IDLE;
      issue_exh = (state_ff == ST_EXH) && issue_ok;
      last_slot = (KW + 1)'(pos_ff) + (KW + 1)'(1) == (KW + 1)'(run_k_ff);
      pos_wide  = PW'(pos_ff);
      head_wide = XW'(head_new);
      issue_meta = '0;
      if (issue_exh) begin
         issue_meta.exhausted = 1'b1;
      end else begin
         issue_meta.position   = pos_wide[3:0];
         issue_meta.item_index = head_wide[5:0];
         issue_meta.last       = last_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b1;
         run_k_ff <= '0;
         base_ff  <= '0;
         pos_ff   <= '0;
         after_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_acc && (op == OP_START)) begin
            done_ff  <= start_bad;
            run_k_ff <= start_bad ? '0 : KW'(subset_size_ff);
            base_ff  <= start_bad ? '0 : n_clamp - NW'(subset_size_ff);
         end else if (ctl.plan && !found) begin
            done_ff <= 1'b1;
         end
         if (ctl.init || ctl.plan) begin
            pos_ff   <= '0;
            after_ff <= 1'b0;
         end else if (ctl.shift) begin
            pos_ff   <= pos_ff + KW'(1);
            after_ff <= after_ff || mark_w[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         prev_ff <= head_new;
      end
   end

   // Element store
   always_comb begin
      load_index_wide = XW'(req_data.load_index);
      ram_waddr       = load_index_wide[IDX_W-1:0];
      ram_we          = req_acc && (op == OP_LOAD) && (int'(req_data.load_index) < MAX_LIST);
   end

   kcg_ram #(
      .WIDTH (32),
      .DEPTH (MAX_LIST)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data.load_value),
      .rd_addr (head_new),
      .rd_data (ram_rdata)
   );

   // Read in flight and result buffer
   always_comb begin
      pop       = rsp_valid && rsp_ready;
      issue_ok  = (3'(cnt_ff) + 3'(infl_valid_ff)) < (3'd2 + 3'(pop));
      push_beat = infl_meta_ff;
      push_beat.item_value = infl_meta_ff.exhausted ? '0 : ram_rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         infl_valid_ff <= 1'b0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         infl_valid_ff <= ctl.shift || issue_exh;
         if (infl_valid_ff) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(infl_valid_ff) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift || issue_exh) begin
         infl_meta_ff <= issue_meta;
      end
      if (infl_valid_ff) begin
         ent_ff[wr_ptr_ff] <= push_beat;
      end
   end

   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = ent_ff[rd_ptr_ff];

   // Checks
   a_exh_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.exhausted |->
         rsp_data.position == '0 && rsp_data.item_index == '0
         && rsp_data.item_value == '0 && !rsp_data.last)
      else $error("exhausted beat carries nonzero fields");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (3'(cnt_ff) + 3'(infl_valid_ff)) <= 3'd2)
      else $error("result buffer overrun");

   a_one_pivot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(mark_vec))
      else $error("more than one pivot mark in the cell row");

   a_start_path: assert property (@(posedge clock) disable iff (reset)
      req_acc && (op == OP_START) |=> state_ff == ST_EMIT || state_ff == ST_EXH)
      else $error("start did not lead to emission");

   a_plan_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLAN && !found |=> done_ff && state_ff == ST_EXH)
      else $error("exhaustion not recorded after planning");

endmodule

// ===== src/kcg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kcg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/kcg_cell.sv =====
// One slot of the chosen-index row: holds an index and a pivot mark.
// Depends on kcg_pkg for the cell control type.
module kcg_cell
   import kcg_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int KW    = 5,
   parameter int NW    = 7,
   parameter int CW    = 7,
   parameter int SLOT  = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [KW-1:0]    run_k,
   input  logic [NW-1:0]    base,
   input  logic [IDX_W-1:0] next_idx,
   input  logic             next_mark,
   input  logic             next_can,
   input  logic [IDX_W-1:0] fb_idx,
   output logic [IDX_W-1:0] idx,
   output logic             mark,
   output logic             can
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             mark_ff, mark_in;
   logic             active;
   logic             tail;

   always_comb begin
      active = int'(run_k) > SLOT;
      tail   = int'(run_k) == SLOT + 1;
      can    = active && (CW'(idx_ff) < (CW'(base) + CW'(SLOT)));
   end

   always_comb begin
      idx_in  = idx_ff;
      mark_in = mark_ff;
      priority if (ctl.init) begin
         idx_in  = IDX_W'(SLOT);
         mark_in = 1'b0;
      end else if (ctl.plan) begin
         mark_in = can && (tail || !next_can);
      end else if (ctl.shift) begin
         idx_in  = tail ? fb_idx : next_idx;
         mark_in = tail ? 1'b0 : next_mark;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         mark_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         mark_ff <= mark_in;
      end
   end

   assign idx  = idx_ff;
   assign mark = mark_ff;

endmodule

// ===== bench/subset_checker.sv =====
// Checker for the k-combination generator: watches the request, result and register ports,
// predicts the subset beats each accepted request should produce and compares them in order.
// Depends on kcg_pkg.
module subset_checker
   import kcg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          errors,
   output int          outstanding
);

   logic [31:0] elems [KCG_MAX_LIST];
   logic [5:0]  picks [KCG_MAX_CHOOSE];
   logic        spent;
   logic [6:0]  len_reg;
   logic [4:0]  size_reg;
   int          run_n;
   int          run_k;
   rsp_type     beats_due [$];
   rsp_type     want;

   function automatic rsp_type make_beat(input logic [3:0] pos, input logic [5:0] idx,
                                         input logic [31:0] val, input logic last,
                                         input logic exh);
      rsp_type beat;
      beat.position   = pos;
      beat.item_index = idx;
      beat.item_value = val;
      beat.last       = last;
      beat.exhausted  = exh;
      return beat;
   endfunction

   function automatic void queue_exhausted();
      beats_due.push_back(make_beat(4'd0, 6'd0, 32'd0, 1'b0, 1'b1));
   endfunction

   function automatic void queue_subset();
      for (int s = 0; s < run_k; s++)
         beats_due.push_back(make_beat(4'(s), picks[s], elems[picks[s]], s == run_k - 1, 1'b0));
   endfunction

   function automatic void start_run();
      int n;
      int k;
      n = (len_reg > KCG_MAX_LIST) ? KCG_MAX_LIST : int'(len_reg);
      k = int'(size_reg);
      if (k == 0 || k > n || k > KCG_MAX_CHOOSE) begin
         spent = 1'b1;
         run_n = 0;
         run_k = 0;
         queue_exhausted();
      end else begin
         run_n = n;
         run_k = k;
         for (int s = 0; s < k; s++) picks[s] = 6'(s);
         spent = 1'b0;
         queue_subset();
      end
   endfunction

   function automatic void advance_run();
      int hit;
      hit = -1;
      if (spent || run_k == 0) begin
         queue_exhausted();
      end else begin
         for (int s = run_k - 1; s >= 0; s--)
            if (hit < 0 && int'(picks[s]) + 1 < run_n - run_k + s + 1) hit = s;
         if (hit < 0) begin
            spent = 1'b1;
            queue_exhausted();
         end else begin
            picks[hit] = picks[hit] + 6'd1;
            for (int j = hit + 1; j < run_k; j++) picks[j] = picks[j - 1] + 6'd1;
            queue_subset();
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < KCG_MAX_CHOOSE; s++) picks[s] = '0;
         spent    = 1'b1;
         len_reg  = '0;
         size_reg = '0;
         run_n    = 0;
         run_k    = 0;
         beats_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (beats_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat: pos %0d idx %0d val %0d last %b exh %b", $time,
                        rsp_data.position, rsp_data.item_index, rsp_data.item_value,
                        rsp_data.last, rsp_data.exhausted);
            end else begin
               want = beats_due.pop_front();
               if (rsp_data.position !== want.position || rsp_data.item_index !== want.item_index
                   || rsp_data.item_value !== want.item_value || rsp_data.last !== want.last
                   || rsp_data.exhausted !== want.exhausted) begin
                  errors++;
                  $display("%0t: beat mismatch: expected pos %0d idx %0d val %0d last %b exh %b",
                           $time, want.position, want.item_index, want.item_value, want.last,
                           want.exhausted);
                  $display("%0t:                actual   pos %0d idx %0d val %0d last %b exh %b",
                           $time, rsp_data.position, rsp_data.item_index, rsp_data.item_value,
                           rsp_data.last, rsp_data.exhausted);
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_LIST_LENGTH, 2'b00}) len_reg = pwdata[6:0];
            else if (paddr == {REG_SUBSET_SIZE, 2'b00}) size_reg = pwdata[4:0];
         end
         if (req_valid && req_ready) begin
            case (req_data.operation)
               OP_LOAD:  elems[req_data.load_index] = req_data.load_value;
               OP_START: start_run();
               OP_NEXT:  advance_run();
               default: ;
            endcase
         end
      end
      outstanding <= beats_due.size();
   end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the k-combination generator: clock, reset, request and register stimulus,
// random result back-pressure and the final verdict.
// Depends on kcg_pkg, k_combination_generator and subset_checker.
module tb;
   import kcg_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 60;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_data  = '0;
   logic        rsp_ready = 1'b0;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [2:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic        req_ready;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic [31:0] prdata;
   logic        pready;
   int          errors;
   int          outstanding;
   int          send_idle  = 0;
   int          recv_stall = 0;
   int          items      = 0;
   logic [KCG_MAX_LIST-1:0] loaded = '0;

   k_combination_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   subset_checker subset_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .errors      (errors),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   task automatic send_beat(input op_type op, input logic [5:0] idx, input logic [31:0] val);
      req_type beat;
      beat.operation  = op;
      beat.load_index = idx;
      beat.load_value = val;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_LOAD) loaded[idx] = 1'b1;
      if (op != OP_NONE) items++;
   endtask

   // hold off until every expected beat is back and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // fill any element a run of this length could read, then program both registers
   task automatic set_regs(input int len, input int size);
      int span;
      span = (len > KCG_MAX_LIST) ? KCG_MAX_LIST : len;
      for (int i = 0; i < span; i++)
         if (!loaded[i]) send_beat(OP_LOAD, 6'(i), $urandom);
      drain();
      write_reg(REG_LIST_LENGTH, 32'(len));
      write_reg(REG_SUBSET_SIZE, 32'(size));
   endtask

   task automatic run_episode();
      int len;
      int size;
      int steps;
      if ($urandom_range(7) == 0) begin
         len  = $urandom_range(127);
         size = $urandom_range(31);
      end else begin
         len  = $urandom_range(1, 9);
         size = $urandom_range(0, len + 1);
      end
      set_regs(len, size);
      if ($urandom_range(9) != 0) send_beat(OP_START, 6'($urandom), $urandom);
      steps = $urandom_range(1, 14);
      for (int i = 0; i < steps; i++) begin
         case ($urandom_range(19))
            0:       send_beat(OP_NONE, 6'($urandom), $urandom);
            1:       send_beat(OP_LOAD, 6'($urandom), $urandom);
            2:       send_beat(OP_START, 6'($urandom), $urandom);
            default: send_beat(OP_NEXT, 6'($urandom), $urandom);
         endcase
      end
   endtask

   initial begin
      int goal;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_beat(OP_NEXT, 6'd0, 32'd0);
      send_beat(OP_NONE, 6'h3F, 32'hFFFF_FFFF);
      send_beat(OP_START, 6'd0, 32'd0);
      send_beat(OP_LOAD, 6'd0, 32'h8000_0000);
      send_beat(OP_LOAD, 6'd1, 32'h7FFF_FFFF);
      send_beat(OP_LOAD, 6'd2, 32'hFFFF_FFFF);
      send_beat(OP_LOAD, 6'h3F, 32'h0000_0000);
      set_regs(3, 2);
      send_beat(OP_START, 6'd0, 32'd0);
      repeat (4) send_beat(OP_NEXT, 6'd0, 32'd0);
      set_regs(2, 3);
      send_beat(OP_START, 6'd0, 32'd0);
      set_regs(64, 16);
      send_beat(OP_START, 6'd0, 32'd0);
      send_beat(OP_NEXT, 6'd0, 32'd0);
      set_regs(5, 1);
      send_beat(OP_NEXT, 6'd0, 32'd0);
      send_beat(OP_START, 6'd0, 32'd0);
      send_beat(OP_NEXT, 6'd0, 32'd0);
      set_regs(64, 17);
      send_beat(OP_START, 6'd0, 32'd0);
      set_regs(127, 31);
      send_beat(OP_START, 6'd0, 32'd0);
      set_regs(100, 2);
      send_beat(OP_START, 6'd0, 32'd0);
      send_beat(OP_NEXT, 6'd0, 32'd0);
      set_regs(4, 4);
      send_beat(OP_START, 6'd0, 32'd0);
      send_beat(OP_NEXT, 6'd0, 32'd0);
      set_regs(0, 0);
      send_beat(OP_START, 6'd0, 32'd0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle  = 0;
               recv_stall = 0;
            end
            1: begin
               send_idle  = 78;
               recv_stall = 0;
            end
            2: begin
               send_idle  = 0;
               recv_stall = 78;
            end
            default: begin
               send_idle  = 6;
               recv_stall = 6;
            end
         endcase
         goal = items + PHASE_ITEMS;
         while (items < goal) run_episode();
      end

      drain();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/kcg_pkg.sv
src/kcg_ram.sv
src/kcg_cell.sv
src/k_combination_generator.sv
bench/subset_checker.sv
bench/tb.sv
